>>> src/lba_to_chs_converter_unit_defines.svh
// Assertion macros for the LBA to CHS converter checkers
`ifndef LBA_TO_CHS_CONVERTER_UNIT_DEFINES_SVH
`define LBA_TO_CHS_CONVERTER_UNIT_DEFINES_SVH

// same-cycle implication, disabled during reset
`define L2C_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled during reset
`define L2C_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

// next-cycle implication that also holds across reset
`define L2C_ASSERT_RST(label, clk, ante, cons, msg) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> src/l2c_pkg.sv
// Package: types, register indexes and reset values of the LBA to CHS converter
package l2c_pkg;

    localparam int SECTOR_BITS_DEF = 32;
    localparam int DIV_BITS_PER_STAGE = 8;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_HEAD_COUNT    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TRACK_SECTORS = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CHS_LIMIT     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_START_SAT     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_END_SAT       = 3'd4;

    localparam logic [7:0]  HEAD_COUNT_RST    = 8'd255;
    localparam logic [5:0]  TRACK_SECTORS_RST = 6'd63;
    localparam logic [31:0] CHS_LIMIT_RST     = 32'd16450559;
    localparam logic [23:0] START_SAT_RST     = 24'hFFFFFE;
    localparam logic [23:0] END_SAT_RST       = 24'hFFFFFE;

    localparam logic STATUS_OK  = 1'b0;
    localparam logic STATUS_ERR = 1'b1;

    typedef struct packed {
        logic [31:0] first_lba;
        logic [31:0] sector_total;
    } t_in_item;

    typedef struct packed {
        logic        status;
        logic [23:0] start_chs;
        logic [23:0] end_chs;
    } t_out_item;

endpackage

>>> src/l2c_div.sv
// Two-lane pipelined restoring divider by a shared narrow divisor
module l2c_div
    import l2c_pkg::*;
#(
    parameter int W   = SECTOR_BITS_DEF,
    parameter int DW  = 8,
    parameter int SW  = 1
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  logic                 i_valid,
    input  logic [1:0][W-1:0]    i_dvd,
    input  logic [DW-1:0]        i_dvs,
    input  logic [SW-1:0]        i_side,
    output logic                 o_valid,
    output logic [1:0][W-1:0]    o_quo,
    output logic [1:0][DW-1:0]   o_rem,
    output logic [SW-1:0]        o_side
);

    localparam int BPS = DIV_BITS_PER_STAGE;
    localparam int NS  = (W + BPS - 1) / BPS;

    logic [NS:0]               r_v;
    logic [1:0][W-1:0]         r_q    [NS+1];
    logic [1:0][DW-1:0]        r_r    [NS+1];
    logic [SW-1:0]             r_side [NS+1];
    logic [1:0][W-1:0]         n_q    [NS+1];
    logic [1:0][DW-1:0]        n_r    [NS+1];

    // one chunk of BPS quotient bits per rank
    always_comb begin
        logic [W-1:0]  q;
        logic [DW-1:0] rr;
        logic [DW:0]   t;
        n_q[0] = i_dvd;
        n_r[0] = '0;
        for (int s = 0; s < NS; s++) begin
            for (int l = 0; l < 2; l++) begin
                q  = r_q[s][l];
                rr = r_r[s][l];
                for (int k = 0; k < BPS; k++) begin
                    if (s * BPS + k < W) begin
                        t = {rr, q[W-1]};
                        q = {q[W-2:0], 1'b0};
                        if (t >= {1'b0, i_dvs}) begin
                            t    = t - {1'b0, i_dvs};
                            q[0] = 1'b1;
                        end
                        rr = t[DW-1:0];
                    end
                end
                n_q[s+1][l] = q;
                n_r[s+1][l] = rr;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[NS-1:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_side[0] <= i_side;
            for (int s = 0; s <= NS; s++) begin
                r_q[s] <= n_q[s];
                r_r[s] <= n_r[s];
            end
            for (int s = 1; s <= NS; s++) begin
                r_side[s] <= r_side[s-1];
            end
        end
    end

    assign o_valid = r_v[NS];
    assign o_quo   = r_q[NS];
    assign o_rem   = r_r[NS];
    assign o_side  = r_side[NS];

endmodule

>>> src/lba_to_chs_converter_unit.sv
// Top level: LBA to CHS converter for one partition table entry
//
// Converts a partition's first LBA and length into MBR-packed start and end
// CHS words, one item per clock unless the output stalls. The pipeline
// holds an input rank, a rank that forms the last sector, then two
// pipelined restoring dividers (LBA / sectors per track, then that
// quotient / heads) that retire eight quotient bits per rank, and the
// output register. The whole pipeline advances together; it freezes
// only while a finished item sits in the output register and is stalled, so
// o_in_stall is high exactly then. Configuration is taken from the write
// port at any time but must only change while the pipeline is empty.
module lba_to_chs_converter_unit
    import l2c_pkg::*;
#(
    parameter int SECTOR_BITS = SECTOR_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  t_in_item              i_in_item,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output t_out_item             o_out_item,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int SB = SECTOR_BITS;

    // configuration registers
    logic [7:0]  r_hd;
    logic [5:0]  r_spt;
    logic [31:0] r_limit;
    logic [23:0] r_start_sat;
    logic [23:0] r_end_sat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hd        <= HEAD_COUNT_RST;
            r_spt       <= TRACK_SECTORS_RST;
            r_limit     <= CHS_LIMIT_RST;
            r_start_sat <= START_SAT_RST;
            r_end_sat   <= END_SAT_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_HEAD_COUNT:    r_hd        <= i_cfg_data[7:0];
                CFG_TRACK_SECTORS: r_spt       <= i_cfg_data[5:0];
                CFG_CHS_LIMIT:     r_limit     <= i_cfg_data;
                CFG_START_SAT:     r_start_sat <= i_cfg_data[23:0];
                CFG_END_SAT:       r_end_sat   <= i_cfg_data[23:0];
                default: ;
            endcase
        end
    end

    logic          w_en;
    logic [SB-1:0] w_limit;

    // global advance: only a stalled, full output register holds things up
    assign w_en       = !(o_out_valid && i_out_stall);
    assign o_in_stall = !w_en;
    assign w_limit    = SB'(r_limit);

    // rank A: input register, LBA reduced to SB bits
    logic          r_a_v;
    logic [SB-1:0] r_a_first;
    logic [SB-1:0] r_a_total;

    // rank B: last sector and the start-over-limit flag
    logic          r_b_v;
    logic [SB-1:0] r_b_first;
    logic [SB-1:0] r_b_last;
    logic          r_b_sov;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_v <= 1'b0;
            r_b_v <= 1'b0;
        end else if (w_en) begin
            r_a_v <= i_in_valid;
            r_b_v <= r_a_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_a_first <= SB'(i_in_item.first_lba);
            r_a_total <= SB'(i_in_item.sector_total);
            r_b_first <= r_a_first;
            r_b_last  <= r_a_first + r_a_total - SB'(1);
            r_b_sov   <= (r_a_first > w_limit);
        end
    end

    // first division: LBA / sectors per track, both sectors side by side
    logic              w_d1_v;
    logic [1:0][SB-1:0] w_d1_q;
    logic [1:0][5:0]   w_d1_r;
    logic [1:0]        w_d1_side;

    l2c_div #(.W(SB), .DW(6), .SW(2)) u_div_track (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r_b_v),
        .i_dvd   ({r_b_last, r_b_first}),
        .i_dvs   (r_spt),
        .i_side  ({r_b_last > w_limit, r_b_sov}),
        .o_valid (w_d1_v),
        .o_quo   (w_d1_q),
        .o_rem   (w_d1_r),
        .o_side  (w_d1_side)
    );

    // second division: track number / heads gives cylinder and head
    logic               w_d2_v;
    logic [1:0][SB-1:0] w_d2_q;
    logic [1:0][7:0]    w_d2_r;
    logic [13:0]        w_d2_side;

    l2c_div #(.W(SB), .DW(8), .SW(14)) u_div_head (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_d1_v),
        .i_dvd   (w_d1_q),
        .i_dvs   (r_hd),
        .i_side  ({w_d1_r[1], w_d1_r[0], w_d1_side}),
        .o_valid (w_d2_v),
        .o_quo   (w_d2_q),
        .o_rem   (w_d2_r),
        .o_side  (w_d2_side)
    );

    // result formation: checks, packing, saturation
    logic       w_sov;
    logic       w_eov;
    logic [5:0] w_rem_s;
    logic [5:0] w_rem_e;
    logic [5:0] w_sect_s;
    logic [5:0] w_sect_e;
    logic [23:0] w_word_s;
    logic [23:0] w_word_e;
    t_out_item  n_out;

    assign w_sov    = w_d2_side[0];
    assign w_eov    = w_d2_side[1];
    assign w_rem_s  = w_d2_side[7:2];
    assign w_rem_e  = w_d2_side[13:8];
    assign w_sect_s = w_rem_s + 6'd1;
    assign w_sect_e = w_rem_e + 6'd1;
    // MBR layout: cyl[7:0], cyl[9:8], sector[5:0], head
    assign w_word_s = {w_d2_q[0][7:0], w_d2_q[0][9:8], w_sect_s, w_d2_r[0]};
    assign w_word_e = {w_d2_q[1][7:0], w_d2_q[1][9:8], w_sect_e, w_d2_r[1]};

    always_comb begin
        n_out = '{status: STATUS_ERR, start_chs: '0, end_chs: '0};
        if (w_sov) begin
            n_out = '{status: STATUS_OK, start_chs: r_start_sat, end_chs: r_end_sat};
        end else if (r_hd == '0 || r_spt == '0) begin
            n_out = '{status: STATUS_ERR, start_chs: '0, end_chs: '0};
        end else if (w_rem_s != '0 || (w_d2_r[0] != 8'd0 && w_d2_r[0] != 8'd1)) begin
            // start not on sector 1 of head 0 or 1
            n_out = '{status: STATUS_ERR, start_chs: '0, end_chs: '0};
        end else if (w_eov) begin
            n_out = '{status: STATUS_OK, start_chs: w_word_s, end_chs: r_end_sat};
        end else if (w_d2_r[1] != r_hd - 8'd1 || w_rem_e != r_spt - 6'd1) begin
            // end not on the last sector of the last head
            n_out = '{status: STATUS_ERR, start_chs: '0, end_chs: '0};
        end else begin
            n_out = '{status: STATUS_OK, start_chs: w_word_s, end_chs: w_word_e};
        end
    end

    // output register
    logic      r_out_v;
    t_out_item r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (w_en) begin
            r_out_v <= w_d2_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_v;
    assign o_out_item  = r_out;

endmodule

>>> src/l2c_checker.sv
// Port-level checker for the LBA to CHS converter, bound to the top level
`include "lba_to_chs_converter_unit_defines.svh"

module l2c_checker
    import l2c_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      o_in_stall,
    input logic      o_out_valid,
    input logic      i_out_stall,
    input t_out_item o_out_item
);

    `L2C_ASSERT_RST(a_rst_clears_out, i_clk, !i_rst_n, !o_out_valid, "output valid after reset")

    `L2C_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid && $stable(o_out_item), "stalled output item changed")

    `L2C_ASSERT_IMP(a_err_zero, i_clk, i_rst_n, o_out_valid && o_out_item.status == STATUS_ERR, o_out_item.start_chs == '0 && o_out_item.end_chs == '0, "error item with nonzero CHS")

    `L2C_ASSERT_IMP(a_in_stall_cause, i_clk, i_rst_n, o_in_stall, o_out_valid && i_out_stall, "input stalled without output back-pressure")

endmodule

bind lba_to_chs_converter_unit l2c_checker u_l2c_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_item  (o_out_item)
);
